[sv/fkv_pkg.sv]
// package with shared types and constants for the hashed key value table
package fkv_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    HS_IDLE,
    HS_MIX,
    HS_PUSH
  } hash_state_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_READ,
    BS_WAIT,
    BS_DECIDE,
    BS_WRITE
  } back_state_e;

  localparam logic [3:0] REG_BUCKET_BITS = 4'd0;

endpackage

[sv/fkv_front.sv]
// front end: takes requests and hashes the key with fnv-1a, one byte a cycle
module fkv_front #(
  parameter int BUCKET_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [1:0]              op_i,
  input  logic [63:0]             key_i,
  input  logic [63:0]             value_i,
  input  logic [3:0]              bucket_bits_i,
  input  logic                    q_full_i,
  output logic                    busy_o,
  output logic                    push_o,
  output logic [1:0]              push_op_o,
  output logic [63:0]             push_key_o,
  output logic [63:0]             push_value_o,
  output logic [BUCKET_BITS-1:0]  push_bucket_o
);
  import fkv_pkg::*;

  hash_state_e state_q, state_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [63:0] hash_q, hash_d;
  logic [1:0]  op_q;
  logic [63:0] key_q, value_q;
  logic [63:0] xored;
  logic [63:0] mixed;
  logic [7:0]  byte_sel;
  logic [4:0]  bits_sat;
  logic [BUCKET_BITS-1:0] mask;
  logic        take;

  assign byte_sel = key_q[{cnt_q, 3'b000} +: 8];
  assign xored    = hash_q ^ {56'd0, byte_sel};
  // prime is 2**40 plus a 9-bit constant
  assign mixed    = (xored << 40) + xored * {55'd0, FNV_PRIME[8:0]};

  always_comb begin
    if ({1'b0, bucket_bits_i} > 5'(BUCKET_BITS)) begin
      bits_sat = 5'(BUCKET_BITS);
    end else begin
      bits_sat = {1'b0, bucket_bits_i};
    end
    for (int i = 0; i < BUCKET_BITS; i++) begin
      mask[i] = (5'(i) < bits_sat);
    end
  end

  assign take          = (state_q == HS_IDLE) && start_i;
  assign busy_o        = (state_q != HS_IDLE);
  assign push_o        = (state_q == HS_PUSH) && !q_full_i;
  assign push_op_o     = op_q;
  assign push_key_o    = key_q;
  assign push_value_o  = value_q;
  assign push_bucket_o = hash_q[BUCKET_BITS-1:0] & mask;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    hash_d  = hash_q;
    case (state_q)
      HS_IDLE: begin
        if (start_i) begin
          state_d = HS_MIX;
          cnt_d   = 3'd0;
          hash_d  = FNV_BASIS;
        end
      end
      HS_MIX: begin
        hash_d = mixed;
        cnt_d  = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          state_d = HS_PUSH;
        end
      end
      HS_PUSH: begin
        if (!q_full_i) begin
          state_d = HS_IDLE;
        end
      end
      default: state_d = HS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HS_IDLE;
      cnt_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hash_q <= hash_d;
    if (take) begin
      op_q    <= op_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
  end

endmodule

[sv/fkv_queue.sv]
// two entry queue between the hash front end and the table back end
module fkv_queue #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] push_data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] pop_data_o
);
  logic [W-1:0] mem_q [2];
  logic         wr_q, rd_q;
  logic [1:0]   cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

[sv/fkv_back.sv]
// back end: reads a bucket row, compares the ways and writes back on insert and delete
module fkv_back #(
  parameter int BUCKET_BITS = 8,
  parameter int WAYS        = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  logic [1:0]             op_i,
  input  logic [63:0]            key_i,
  input  logic [63:0]            value_i,
  input  logic [BUCKET_BITS-1:0] bucket_i,
  output logic                   pop_o,
  output logic                   done_o,
  output logic [1:0]             status_o,
  output logic [63:0]            value_read_o
);
  import fkv_pkg::*;

  localparam int NB = 1 << BUCKET_BITS;
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1;

  back_state_e state_q, state_d;
  logic [BUCKET_BITS-1:0] clr_q;
  logic                   clr_busy_q;

  logic [WAYS-1:0]  valid_mem [NB];
  logic [63:0]      key_mem   [NB][WAYS];
  logic [63:0]      val_mem   [NB][WAYS];

  logic [1:0]             op_q;
  logic [63:0]            key_q, value_q;
  logic [BUCKET_BITS-1:0] bkt_q;
  logic [WAYS-1:0]        vrow_q;
  logic [63:0]            krow_q [WAYS];
  logic [63:0]            drow_q [WAYS];

  logic            hit_q, free_q;
  logic [WW-1:0]   hit_w_q, free_w_q;
  logic            hit_c, free_c;
  logic [WW-1:0]   hit_w_c, free_w_c;

  logic            wr_valid, wr_entry;
  logic [WW-1:0]   wr_way;
  logic [WAYS-1:0] vrow_new;
  logic [1:0]      status_d;
  logic [63:0]     rd_d;

  always_comb begin
    hit_c    = 1'b0;
    free_c   = 1'b0;
    hit_w_c  = '0;
    free_w_c = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (vrow_q[w] && (krow_q[w] == key_q)) begin
        hit_c   = 1'b1;
        hit_w_c = WW'(w);
      end
      if (!vrow_q[w]) begin
        free_c   = 1'b1;
        free_w_c = WW'(w);
      end
    end
  end

  assign pop_o  = (state_q == BS_IDLE) && !clr_busy_q && !empty_i;

  always_comb begin
    state_d  = state_q;
    wr_valid = 1'b0;
    wr_entry = 1'b0;
    wr_way   = hit_w_q;
    vrow_new = vrow_q;
    status_d = ST_MISSING;
    rd_d     = 64'd0;
    case (state_q)
      BS_IDLE:   if (pop_o) state_d = BS_READ;
      BS_READ:   state_d = BS_WAIT;
      BS_WAIT:   state_d = BS_DECIDE;
      BS_DECIDE: state_d = BS_WRITE;
      BS_WRITE: begin
        state_d = BS_IDLE;
        case (op_q)
          OP_INSERT: begin
            if (hit_q) begin
              wr_entry = 1'b1;
              status_d = ST_OK;
            end else if (free_q) begin
              wr_entry = 1'b1;
              wr_valid = 1'b1;
              wr_way   = free_w_q;
              vrow_new[free_w_q] = 1'b1;
              status_d = ST_OK;
            end else begin
              status_d = ST_FULL;
            end
          end
          OP_DELETE: begin
            if (hit_q) begin
              wr_valid = 1'b1;
              vrow_new[hit_w_q] = 1'b0;
              status_d = ST_OK;
            end
          end
          OP_GET: begin
            if (hit_q) begin
              status_d = ST_OK;
              rd_d     = drow_q[hit_w_q];
            end
          end
          default: status_d = ST_MISSING;
        endcase
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BS_IDLE;
      clr_q      <= '0;
      clr_busy_q <= 1'b1;
      done_o     <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == BS_WRITE);
      if (clr_busy_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == {BUCKET_BITS{1'b1}}) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_o     <= status_d;
    value_read_o <= rd_d;
    if (pop_o) begin
      op_q    <= op_i;
      key_q   <= key_i;
      value_q <= value_i;
      bkt_q   <= bucket_i;
    end
    if (state_q == BS_READ) begin
      vrow_q <= valid_mem[bkt_q];
      for (int w = 0; w < WAYS; w++) begin
        krow_q[w] <= key_mem[bkt_q][w];
        drow_q[w] <= val_mem[bkt_q][w];
      end
    end
    if (state_q == BS_DECIDE) begin
      hit_q    <= hit_c;
      free_q   <= free_c;
      hit_w_q  <= hit_w_c;
      free_w_q <= free_w_c;
    end
    if (clr_busy_q) begin
      valid_mem[clr_q] <= '0;
    end else if (wr_valid) begin
      valid_mem[bkt_q] <= vrow_new;
    end
    if (wr_entry) begin
      key_mem[bkt_q][wr_way] <= key_q;
      val_mem[bkt_q][wr_way] <= value_q;
    end
  end

endmodule

[sv/fnv1a_hashed_key_value_table_top.sv]
// top level of the fnv-1a hashed key value table
// usage: pulse start with op_i, key_i and value_i while busy is low.
// the front end hashes the key over its eight bytes (one byte and one 64-bit
// multiply a cycle), then pushes the request into a two word queue.
// the back end pops a word, reads the bucket row from the table memory,
// compares all ways, writes back and shows the result.
// each result is on status_o and value_read_o for one cycle with done_o
// high; the receiver cannot stall it.
// a request goes from the hash loop through the queue to the back end; a
// new request is taken once the front end has pushed the last one.
// busy is high while the front end hashes or waits to push into a full queue.
// after reset the back end clears the valid bits one bucket row a cycle,
// over all 2**BUCKET_BITS rows; requests queue up behind that pass.
// bucket_bits is written through the apb port at address 0; values above
// BUCKET_BITS saturate. write it only while the block is idle.
module fnv1a_hashed_key_value_table_top #(
  parameter int BUCKET_BITS = 8,
  parameter int WAYS        = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [63:0] key_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [63:0] value_read_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fkv_pkg::*;

  localparam int QW = 2 + 64 + 64 + BUCKET_BITS;

  logic [3:0] bucket_bits_q;
  logic       f_push, q_full, q_empty, b_pop;
  logic [1:0] f_op;
  logic [63:0] f_key, f_val;
  logic [BUCKET_BITS-1:0] f_bkt;
  logic [QW-1:0] q_out;

  assign pready = 1'b1;
  assign prdata = {28'd0, bucket_bits_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_bits_q <= 4'd8;
    end else if (psel && penable && pwrite && paddr == REG_BUCKET_BITS[1:0]) begin
      bucket_bits_q <= pwdata[3:0];
    end
  end

  fkv_front #(.BUCKET_BITS(BUCKET_BITS)) u_front (
    .clk_i, .rst_ni,
    .start_i       (start && !busy),
    .op_i, .key_i, .value_i,
    .bucket_bits_i (bucket_bits_q),
    .q_full_i      (q_full),
    .busy_o        (busy),
    .push_o        (f_push),
    .push_op_o     (f_op),
    .push_key_o    (f_key),
    .push_value_o  (f_val),
    .push_bucket_o (f_bkt)
  );

  fkv_queue #(.W(QW)) u_queue (
    .clk_i, .rst_ni,
    .push_i      (f_push),
    .push_data_i ({f_op, f_key, f_val, f_bkt}),
    .full_o      (q_full),
    .pop_i       (b_pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_out)
  );

  fkv_back #(.BUCKET_BITS(BUCKET_BITS), .WAYS(WAYS)) u_back (
    .clk_i, .rst_ni,
    .empty_i      (q_empty),
    .op_i         (q_out[QW-1 -: 2]),
    .key_i        (q_out[QW-3 -: 64]),
    .value_i      (q_out[BUCKET_BITS+63 -: 64]),
    .bucket_i     (q_out[BUCKET_BITS-1:0]),
    .pop_o        (b_pop),
    .done_o,
    .status_o,
    .value_read_o
  );

endmodule

[sv/fkv_checker.sv]
// port level checker for the hashed key value table, bound to the top level
module fkv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [63:0] value_read_o,
  input logic        pready
);
  import fkv_pkg::*;

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o != ST_UNUSED) else $error("bad status");

  a_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> value_read_o == 64'd0) else $error("value not zero");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("not busy after accept");

  a_ready: assert property (@(posedge clk_i) pready) else $error("pready low");

endmodule

bind fnv1a_hashed_key_value_table_top fkv_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .status_o, .value_read_o, .pready
);
